// ----- rtl/assert_macros.svh -----
// Assertion helpers used by decimal_line_parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted
`define DLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define DLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/dlp_pkg.sv -----
package dlp_pkg;

    localparam int MAX_LINE_BYTES = 10;
    localparam int LINE_CNT_W     = $clog2(MAX_LINE_BYTES + 1);

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 31;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CODE_NINE    = 8'd57;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RST = {VALUE_W{1'b1}};

    // register word indexes
    localparam logic [APB_ADDR_W-3:0] REG_MAX_VALUE = '0;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TRAIL  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PARSE = 2'd1,
        ST_READ  = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_result;

endpackage

// ----- rtl/dlp_apb_regs.sv -----
module dlp_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dlp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dlp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dlp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [dlp_pkg::VALUE_W-1:0]      o_max_value
);

    logic [dlp_pkg::VALUE_W-1:0] r_max_value;
    logic                        sel_max;

    assign sel_max = (paddr[dlp_pkg::APB_ADDR_W-1:2] == dlp_pkg::REG_MAX_VALUE);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= dlp_pkg::MAX_VALUE_RST;
        end else if (psel && penable && pwrite && pready && sel_max) begin
            r_max_value <= pwdata[dlp_pkg::VALUE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_max) begin
            prdata = dlp_pkg::APB_DATA_W'(r_max_value);
        end
    end

    assign o_max_value = r_max_value;

endmodule

// ----- rtl/dlp_parse_core.sv -----
module dlp_parse_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [dlp_pkg::CHAR_W-1:0]    i_char,
    input  logic                          i_eoi,
    input  logic [dlp_pkg::VALUE_W-1:0]   i_max_value,
    output logic                          o_line_end,
    output dlp_pkg::t_result              o_result
);

    localparam int CNT_W  = dlp_pkg::LINE_CNT_W;
    localparam int WIDE_W = dlp_pkg::VALUE_W + 4;

    dlp_pkg::t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [dlp_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic                        r_err, n_err;
    logic                        r_saw, n_saw;

    logic                        is_end;
    logic                        is_digit;
    logic [WIDE_W-1:0]           acc_wide;
    logic [WIDE_W-1:0]           acc_next;

    assign is_end   = i_eoi || (i_char == dlp_pkg::CODE_NEWLINE);
    assign is_digit = (i_char >= dlp_pkg::CODE_ZERO) && (i_char <= dlp_pkg::CODE_NINE);
    assign acc_wide = WIDE_W'(r_acc);
    // acc * 10 + digit; low nibble of '0'..'9' is the digit value
    assign acc_next = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(i_char[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dlp_pkg::PH_LEAD;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_err   <= 1'b0;
            r_saw   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_err   <= n_err;
            r_saw   <= n_saw;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_err      = r_err;
        n_saw      = r_saw;
        o_line_end = 1'b0;
        o_result.value  = '0;
        o_result.status = dlp_pkg::ST_OK;

        if (i_eoi) begin
            o_result.status = dlp_pkg::ST_READ;
        end else if (r_err || !r_saw) begin
            o_result.status = dlp_pkg::ST_PARSE;
        end else begin
            o_result.value = r_acc;
        end

        if (i_take) begin
            if (is_end) begin
                o_line_end = 1'b1;
                n_phase    = dlp_pkg::PH_LEAD;
                n_cnt      = '0;
                n_acc      = '0;
                n_err      = 1'b0;
                n_saw      = 1'b0;
            end else if (r_cnt >= CNT_W'(dlp_pkg::MAX_LINE_BYTES)) begin
                // over-long line: byte is dropped, count saturates
                n_err = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
                if (i_char <= dlp_pkg::CODE_SPACE) begin
                    if (r_phase == dlp_pkg::PH_DIGITS) begin
                        n_phase = dlp_pkg::PH_TRAIL;
                    end
                end else if (is_digit) begin
                    if (r_phase == dlp_pkg::PH_TRAIL) begin
                        n_err = 1'b1;
                    end else begin
                        n_phase = dlp_pkg::PH_DIGITS;
                        n_saw   = 1'b1;
                        if (!r_err) begin
                            if (acc_next > WIDE_W'(i_max_value)) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc = acc_next[dlp_pkg::VALUE_W-1:0];
                            end
                        end
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/decimal_line_parser.sv -----
// Path: a byte that ends a line goes into the input register, then its result
// goes into the result register; an output stall can hold it in the input register.
// Throughput: one byte per cycle; set by the combinational x10 accumulate and
// max compare in the parse core. While a result waits on m_axis_tready the
// input register cannot drain, so input stops after one more byte.
// Reset: synchronous, active low; clears parser state and both valid flags.
`include "assert_macros.svh"

module decimal_line_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] char_code
    input  logic                             s_axis_tuser,  // [0] end_of_input
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // [30:0] value, [31] zero
    output logic [1:0]                       m_axis_tuser,  // [1:0] status
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dlp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dlp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dlp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic                        r_in_valid;
    logic [dlp_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_in_eoi;
    logic                        r_out_valid;
    dlp_pkg::t_result            r_out;

    logic                        take;
    logic                        line_end;
    dlp_pkg::t_result            result;
    logic [dlp_pkg::VALUE_W-1:0] max_value;

    // item in the input register moves on when the result register is free or is being read out
    assign take          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || take;

    dlp_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_value (max_value)
    );

    dlp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char      (r_in_char),
        .i_eoi       (r_in_eoi),
        .i_max_value (max_value),
        .o_line_end  (line_end),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_eoi  <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && line_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && line_end) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 32'(r_out.value);
    assign m_axis_tuser  = r_out.status;

    `DLP_ASSERT(a_ok_within_max, r_out_valid && r_out.status == dlp_pkg::ST_OK |-> r_out.value <= max_value, "ok result above max_value")
    `DLP_ASSERT(a_err_value_zero, r_out_valid && r_out.status != dlp_pkg::ST_OK |-> r_out.value == '0, "error result with non-zero value")
    `DLP_ASSERT(a_stall_holds_input, r_in_valid && r_out_valid && !m_axis_tready |=> r_in_valid && $stable(r_in_char) && $stable(r_in_eoi), "input item lost during output stall")
    `DLP_ASSERT_ALWAYS(a_ready_when_empty, !r_in_valid |-> s_axis_tready, "input not ready with empty input register")

endmodule
